@@ sv/lli_pkg.sv @@
`timescale 1ns / 1ps
package lli_pkg;
   localparam int DEF_COORD_BITS = 16;
   localparam int DEF_FRAC_BITS  = 16;
   localparam int OUT_W          = 48;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic CSR_IDX_INTEGER_RESULT = 1'b0;
endpackage

@@ sv/lli_if.sv @@
`timescale 1ns / 1ps
interface lli_req_if import lli_pkg::*; #(parameter int COORD_BITS = DEF_COORD_BITS) ();
   logic valid;
   logic ready;
   logic signed [COORD_BITS-1:0] line_a_x1;
   logic signed [COORD_BITS-1:0] line_a_y1;
   logic signed [COORD_BITS-1:0] line_a_x2;
   logic signed [COORD_BITS-1:0] line_a_y2;
   logic signed [COORD_BITS-1:0] line_b_x1;
   logic signed [COORD_BITS-1:0] line_b_y1;
   logic signed [COORD_BITS-1:0] line_b_x2;
   logic signed [COORD_BITS-1:0] line_b_y2;
   modport source (output valid, line_a_x1, line_a_y1, line_a_x2, line_a_y2,
                   line_b_x1, line_b_y1, line_b_x2, line_b_y2, input ready);
   modport sink (input valid, line_a_x1, line_a_y1, line_a_x2, line_a_y2,
                 line_b_x1, line_b_y1, line_b_x2, line_b_y2, output ready);
endinterface

interface lli_rsp_if import lli_pkg::*; ();
   logic valid;
   logic ready;
   logic parallel;
   logic saturated;
   logic signed [OUT_W-1:0] cross_x;
   logic signed [OUT_W-1:0] cross_y;
   modport source (output valid, parallel, saturated, cross_x, cross_y, input ready);
   modport sink (input valid, parallel, saturated, cross_x, cross_y, output ready);
endinterface

@@ sv/lli_front.sv @@
`timescale 1ns / 1ps
module lli_front import lli_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  logic clock,
   input  logic reset,
   lli_req_if.sink req_ch,
   input  logic full,
   output logic push,
   output logic [2*(3*COORD_BITS+3)+2*COORD_BITS+2:0] push_data
);
   localparam int C  = COORD_BITS;
   localparam int DW = C + 1;
   localparam int PW = 2 * C;
   localparam int EW = 2 * C + 2;
   localparam int KW = 2 * C + 1;
   localparam int GW = 2 * C + 3;
   localparam int MW = 3 * C + 2;
   localparam int NW = 3 * C + 3;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DW-1:0] dxa1_ff, dya1_ff, dxb1_ff, dyb1_ff;
   logic signed [DW-1:0] dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [PW-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [EW-1:0] e1_ff, e2_ff;
   logic signed [KW-1:0] da_ff, db_ff;
   logic signed [GW-1:0] den3_ff, den4_ff;
   logic signed [MW-1:0] m1_ff, m2_ff, m3_ff, m4_ff;
   logic signed [NW-1:0] nx_ff, ny_ff;

   assign adv          = !(v4_ff && full);
   assign req_ch.ready = adv;
   assign push         = v4_ff && !full;
   assign push_data    = {nx_ff, ny_ff, den4_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_ch.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dxa1_ff <= DW'(req_ch.line_a_x1) - DW'(req_ch.line_a_x2);
         dya1_ff <= DW'(req_ch.line_a_y1) - DW'(req_ch.line_a_y2);
         dxb1_ff <= DW'(req_ch.line_b_x1) - DW'(req_ch.line_b_x2);
         dyb1_ff <= DW'(req_ch.line_b_y1) - DW'(req_ch.line_b_y2);
         pa_ff   <= PW'(req_ch.line_a_x1) * PW'(req_ch.line_a_y2);
         pb_ff   <= PW'(req_ch.line_a_y1) * PW'(req_ch.line_a_x2);
         pc_ff   <= PW'(req_ch.line_b_x1) * PW'(req_ch.line_b_y2);
         pd_ff   <= PW'(req_ch.line_b_y1) * PW'(req_ch.line_b_x2);

         e1_ff   <= EW'(dxa1_ff) * EW'(dyb1_ff);
         e2_ff   <= EW'(dya1_ff) * EW'(dxb1_ff);
         da_ff   <= KW'(pa_ff) - KW'(pb_ff);
         db_ff   <= KW'(pc_ff) - KW'(pd_ff);
         dxa2_ff <= dxa1_ff;
         dya2_ff <= dya1_ff;
         dxb2_ff <= dxb1_ff;
         dyb2_ff <= dyb1_ff;

         den3_ff <= GW'(e1_ff) - GW'(e2_ff);
         m1_ff   <= MW'(da_ff) * MW'(dxb2_ff);
         m2_ff   <= MW'(db_ff) * MW'(dxa2_ff);
         m3_ff   <= MW'(da_ff) * MW'(dyb2_ff);
         m4_ff   <= MW'(db_ff) * MW'(dya2_ff);

         den4_ff <= den3_ff;
         nx_ff   <= NW'(m1_ff) - NW'(m2_ff);
         ny_ff   <= NW'(m3_ff) - NW'(m4_ff);
      end
   end
endmodule

@@ sv/lli_queue.sv @@
`timescale 1ns / 1ps
module lli_queue import lli_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [WIDTH-1:0] push_data,
   input  logic pop,
   output logic [WIDTH-1:0] pop_data,
   output logic full,
   output logic empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule

@@ sv/lli_back.sv @@
`timescale 1ns / 1ps
module lli_back import lli_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic integer_result,
   input  logic empty,
   input  logic [2*(3*COORD_BITS+3)+2*COORD_BITS+2:0] pop_data,
   output logic pop,
   lli_rsp_if.source rsp_ch
);
   localparam int C  = COORD_BITS;
   localparam int GW = 2 * C + 3;
   localparam int NW = 3 * C + 3;
   localparam int QW = 2 * NW + GW;
   localparam int XW = NW + FRAC_BITS;
   localparam int CW = (XW > OUT_W) ? XW : OUT_W;

   logic adv;
   logic signed [NW-1:0] nx, ny;
   logic signed [GW-1:0] den;
   logic [NW-1:0] mag_x, mag_y;

   logic          val_ff  [0:XW];
   logic          negx_ff [0:XW];
   logic          negy_ff [0:XW];
   logic          par_ff  [0:XW];
   logic [GW-1:0] d_ff    [0:XW];
   logic [GW-1:0] rx_ff   [0:XW];
   logic [GW-1:0] ry_ff   [0:XW];
   logic [XW-1:0] wx_ff   [0:XW];
   logic [XW-1:0] wy_ff   [0:XW];
   logic [GW-1:0] rx_in   [0:XW-1];
   logic [GW-1:0] ry_in   [0:XW-1];
   logic [XW-1:0] wx_in   [0:XW-1];
   logic [XW-1:0] wy_in   [0:XW-1];

   logic [CW-1:0] qx, qy, limx, limy;
   logic sat_x, sat_y;
   logic [OUT_W-1:0] vx, vy, mx, my, frac_mask;

   logic rsp_valid_ff, par_out_ff, sat_out_ff;
   logic [OUT_W-1:0] cross_x_ff, cross_y_ff;

   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign pop = adv && !empty;
   assign nx  = pop_data[QW-1 -: NW];
   assign ny  = pop_data[QW-NW-1 -: NW];
   assign den = pop_data[GW-1:0];
   assign mag_x = nx[NW-1] ? NW'(-nx) : NW'(nx);
   assign mag_y = ny[NW-1] ? NW'(-ny) : NW'(ny);

   always_comb begin
      logic [GW:0] tx, ty;
      for (int k = 0; k < XW; k++) begin
         tx = {rx_ff[k], wx_ff[k][XW-1]};
         ty = {ry_ff[k], wy_ff[k][XW-1]};
         if (tx >= {1'b0, d_ff[k]}) begin
            rx_in[k] = GW'(tx - {1'b0, d_ff[k]});
            wx_in[k] = {wx_ff[k][XW-2:0], 1'b1};
         end else begin
            rx_in[k] = tx[GW-1:0];
            wx_in[k] = {wx_ff[k][XW-2:0], 1'b0};
         end
         if (ty >= {1'b0, d_ff[k]}) begin
            ry_in[k] = GW'(ty - {1'b0, d_ff[k]});
            wy_in[k] = {wy_ff[k][XW-2:0], 1'b1};
         end else begin
            ry_in[k] = ty[GW-1:0];
            wy_in[k] = {wy_ff[k][XW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= XW; k++) begin
            val_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         val_ff[0] <= !empty;
         for (int k = 0; k < XW; k++) begin
            val_ff[k+1] <= val_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         negx_ff[0] <= nx[NW-1] ^ den[GW-1];
         negy_ff[0] <= ny[NW-1] ^ den[GW-1];
         par_ff[0]  <= (den == '0);
         d_ff[0]    <= den[GW-1] ? GW'(-den) : GW'(den);
         rx_ff[0]   <= '0;
         ry_ff[0]   <= '0;
         wx_ff[0]   <= XW'(mag_x) << FRAC_BITS;
         wy_ff[0]   <= XW'(mag_y) << FRAC_BITS;
         for (int k = 0; k < XW; k++) begin
            negx_ff[k+1] <= negx_ff[k];
            negy_ff[k+1] <= negy_ff[k];
            par_ff[k+1]  <= par_ff[k];
            d_ff[k+1]    <= d_ff[k];
            rx_ff[k+1]   <= rx_in[k];
            ry_ff[k+1]   <= ry_in[k];
            wx_ff[k+1]   <= wx_in[k];
            wy_ff[k+1]   <= wy_in[k];
         end
      end
   end

   assign qx   = CW'(wx_ff[XW]);
   assign qy   = CW'(wy_ff[XW]);
   assign limx = negx_ff[XW] ? (CW'(1) << (OUT_W - 1)) : ((CW'(1) << (OUT_W - 1)) - 1'b1);
   assign limy = negy_ff[XW] ? (CW'(1) << (OUT_W - 1)) : ((CW'(1) << (OUT_W - 1)) - 1'b1);
   assign sat_x = qx > limx;
   assign sat_y = qy > limy;
   assign frac_mask = (OUT_W'(1) << FRAC_BITS) - 1'b1;
   assign vx = sat_x ? limx[OUT_W-1:0] : qx[OUT_W-1:0];
   assign vy = sat_y ? limy[OUT_W-1:0] : qy[OUT_W-1:0];
   assign mx = integer_result ? (vx & ~frac_mask) : vx;
   assign my = integer_result ? (vy & ~frac_mask) : vy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= val_ff[XW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         par_out_ff <= par_ff[XW];
         if (par_ff[XW]) begin
            sat_out_ff <= 1'b0;
            cross_x_ff <= '0;
            cross_y_ff <= '0;
         end else begin
            sat_out_ff <= sat_x || sat_y;
            cross_x_ff <= negx_ff[XW] ? -mx : mx;
            cross_y_ff <= negy_ff[XW] ? -my : my;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.parallel  = par_out_ff;
   assign rsp_ch.saturated = sat_out_ff;
   assign rsp_ch.cross_x   = cross_x_ff;
   assign rsp_ch.cross_y   = cross_y_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && par_out_ff |-> (cross_x_ff == '0) && (cross_y_ff == '0) && !sat_out_ff)
      else $error("Parallel result carries non-zero fields.");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && integer_result |-> ((cross_x_ff & frac_mask) == '0)
                                       && ((cross_y_ff & frac_mask) == '0))
      else $error("Integer result keeps fraction bits.");
   assert property (@(posedge clock) disable iff (reset)
      val_ff[XW] && !adv |=> val_ff[XW])
      else $error("Divider pipeline lost a request while stalled.");
endmodule

@@ sv/line_line_intersection_top.sv @@
`timescale 1ns / 1ps
// Line intersection by determinants.
// Requests arrive on req_ch (valid/ready): two lines, each as two signed integer points.
// Each request gives exactly one result on rsp_ch (valid/ready): the parallel and
// saturated flags and the crossing point as signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero.
// From acceptance to rsp_ch.valid a request passes four front stages of products
// and differences, the queue, one sign stage, one restoring division stage per
// quotient bit and the output register.
// One request per cycle goes through unless rsp_ch stalls; division is fully pipelined.
// A stalled receiver holds the output register and the division pipeline; the
// four-entry queue then fills and req_ch.ready falls once the front stalls on it.
// The register integer_result (byte address 0) clears the fraction bits of each
// coordinate when set; write it only while no request is in flight.
// Synchronous reset empties the pipelines and the queue and clears integer_result.
module line_line_intersection_top import lli_pkg::*; #(
   parameter int COORD_BITS = DEF_COORD_BITS,
   parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   lli_req_if.sink   req_ch,
   lli_rsp_if.source rsp_ch,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic csr_pready
);
   localparam int QW = 2 * (3 * COORD_BITS + 3) + 2 * COORD_BITS + 3;

   logic integer_result_ff;
   logic push, pop, full, empty;
   logic [QW-1:0] push_data, pop_data;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_INTEGER_RESULT)
                       ? {{(CSR_DATA_BITS-1){1'b0}}, integer_result_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         integer_result_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == CSR_IDX_INTEGER_RESULT) begin
         integer_result_ff <= csr_pwdata[0];
      end
   end

   lli_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock(clock), .reset(reset), .req_ch(req_ch),
      .full(full), .push(push), .push_data(push_data)
   );

   lli_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .full(full), .empty(empty)
   );

   lli_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .integer_result(integer_result_ff),
      .empty(empty), .pop_data(pop_data), .pop(pop), .rsp_ch(rsp_ch)
   );
endmodule
